### hw/rtl/binary_outline_pixel_extractor_defines.svh
// Assertion macros used by the outline pixel extractor RTL.
`ifndef BINARY_OUTLINE_PIXEL_EXTRACTOR_DEFINES_SVH
`define BINARY_OUTLINE_PIXEL_EXTRACTOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BOPE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BOPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bope_pkg.sv
// Types and constants of the binary outline pixel extractor.
package bope_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;

  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;

  typedef logic [COL_W-1:0]    col_t;
  typedef logic [ROW_W-1:0]    row_t;
  typedef logic [WIDTH_W-1:0]  width_t;
  typedef logic [HEIGHT_W-1:0] height_t;

  // Register indexes, taken from the word address.
  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  localparam width_t  WIDTH_RST  = width_t'(1024);
  localparam height_t HEIGHT_RST = height_t'(1024);

  // Result slots of one pixel transaction, in delivery order.
  localparam int RES_ABOVE = 0;
  localparam int RES_LEFT  = 1;
  localparam int RES_OWN   = 2;
  localparam int RES_N     = 3;

  // One line store entry: the newer and the older row at one column.
  typedef struct packed {
    logic m1;
    logic m2;
  } line_t;

endpackage

### hw/rtl/bope_if.sv
// Pixel and result channel interfaces of the outline pixel extractor.
interface bope_in_if;
  import bope_pkg::*;
  logic valid;
  logic ready;
  logic pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface bope_out_if;
  import bope_pkg::*;
  logic valid;
  logic ready;
  logic outline;
  col_t col;
  row_t row;
  logic frame_end;
  modport source (output valid, output outline, output col, output row, output frame_end,
                  input ready);
  modport sink (input valid, input outline, input col, input row, input frame_end,
                output ready);
endinterface

### hw/rtl/binary_outline_pixel_extractor.sv
// Results are registered in the result stage, then in the output register. Throughput: one
// pixel per cycle while the output is ready; a pixel owing several results holds the input until
// its last one leaves, and only last-row pixels owe more than one (up to three: above, left, own).
// The rate is set by the one output register and the line store's single read and write port.
// Reset (rst_n, synchronous, active low) clears counters, result queue and output valid, and
// restores the size registers; the line store is not cleared, as row tests never read stale entries.
module binary_outline_pixel_extractor (
  input  logic                            clk,
  input  logic                            rst_n,
  bope_in_if.sink                         in_ch,
  bope_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [bope_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [bope_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [bope_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                            cfg_pready
);
  import bope_pkg::*;

  `include "binary_outline_pixel_extractor_defines.svh"

  // ---------------------------------------------------------------------------
  // Configuration registers. The word address picks the register; the low two
  // byte-address bits are ignored. Every transaction completes without wait.
  // ---------------------------------------------------------------------------
  width_t  width_r;
  height_t height_r;
  logic    cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_IDX_WIDTH:  width_r  <= cfg_pwdata[WIDTH_W-1:0];
        REG_IDX_HEIGHT: height_r <= cfg_pwdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_IDX_WIDTH:  cfg_prdata = {{(CFG_DW-WIDTH_W){1'b0}}, width_r};
      REG_IDX_HEIGHT: cfg_prdata = {{(CFG_DW-HEIGHT_W){1'b0}}, height_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // A size of zero counts as one, and anything above the maximum counts as
  // the maximum.
  width_t  w_eff;
  height_t h_eff;

  always_comb begin
    if (width_r == '0)                          w_eff = width_t'(1);
    else if (width_r > width_t'(MAX_WIDTH))     w_eff = width_t'(MAX_WIDTH);
    else                                        w_eff = width_r;
    if (height_r == '0)                         h_eff = height_t'(1);
    else if (height_r > height_t'(MAX_HEIGHT))  h_eff = height_t'(MAX_HEIGHT);
    else                                        h_eff = height_r;
  end

  // ---------------------------------------------------------------------------
  // Position counters and per-row history. The counters give the position of
  // the next pixel. A column at or beyond the width ends its row, and a row at
  // or beyond the height is the last one, so a size change between frames
  // still leaves the counters on a sensible path.
  // ---------------------------------------------------------------------------
  col_t col_r, col_nxt;
  row_t row_r, row_nxt;
  logic left_px_r;   // previous pixel of the current row
  logic a1_r;        // newer row value of the previous column
  logic last_col, last_row;
  logic in_acc;

  assign last_col = ({1'b0, col_r} + width_t'(1)) >= w_eff;
  assign last_row = ({1'b0, row_r} + height_t'(1)) >= h_eff;
  assign in_acc   = in_ch.valid && in_ch.ready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + row_t'(1);
      end else begin
        col_nxt = col_r + col_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      left_px_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_acc) begin
        left_px_r <= last_col ? 1'b0 : in_ch.pixel;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line store. Each entry holds the two previous rows at one column. The read
  // port always fetches the entry of the column that comes next, so the entry
  // of the current column is already waiting in the read register when a pixel
  // arrives. That same cycle the entry is written back, shifted by one row,
  // with the new pixel. When the next column is the current one (a one-pixel
  // wide image) the write data is forwarded instead of the stale read.
  // ---------------------------------------------------------------------------
  line_t line_mem [MAX_WIDTH];
  line_t mem_q_r;
  line_t fwd_d_r;
  logic  fwd_r;
  line_t rd;
  line_t wr_d;
  col_t  nxt_addr;

  assign rd       = fwd_r ? fwd_d_r : mem_q_r;
  assign wr_d     = '{m1: in_ch.pixel, m2: rd.m1};
  assign nxt_addr = last_col ? '0 : col_r + col_t'(1);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      line_mem[col_r] <= wr_d;
      mem_q_r         <= line_mem[nxt_addr];
      fwd_d_r         <= wr_d;
      a1_r            <= rd.m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (in_acc) begin
      fwd_r <= (nxt_addr == col_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Result stage. An accepted pixel leaves its neighbourhood here together with
  // a mask of the results it owes: the pixel above (from the second row on),
  // the left neighbour (last row only) and itself (final pixel of the frame).
  // The right neighbour of the pixel above is the next column of the newer
  // row, which the read register holds from the cycle after acceptance on and
  // keeps until the next pixel transaction. In the last row the down neighbour
  // lies outside the image, so the left and own results are the pixel values.
  // ---------------------------------------------------------------------------
  logic [RES_N-1:0] pend_r, pend_nxt, pend_new;
  col_t b_col_r;
  row_t b_row_r;
  logic b_px_r, b_left_r, b_m1c_r, b_l_r, b_u_r, b_last_col_r;

  assign pend_new[RES_ABOVE] = (row_r != '0);
  assign pend_new[RES_LEFT]  = last_row && (col_r != '0);
  assign pend_new[RES_OWN]   = last_row && last_col;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_col_r      <= col_r;
      b_row_r      <= row_r;
      b_px_r       <= in_ch.pixel;
      b_left_r     <= left_px_r;
      b_m1c_r      <= rd.m1;
      b_l_r        <= (col_r != '0) && a1_r;
      b_u_r        <= (row_r >= row_t'(2)) && rd.m2;
      b_last_col_r <= last_col;
    end
  end

  logic above_rt, above_outline;

  assign above_rt      = !b_last_col_r && rd.m1;
  assign above_outline = b_m1c_r && !(b_l_r && above_rt && b_u_r && b_px_r);

  // ---------------------------------------------------------------------------
  // Output register. Results leave one per cycle while the receiver is ready, in the order
  // above, left, own. A new pixel is taken when at most the last owed result is still in
  // the queue and it moves to the output register in this cycle.
  // ---------------------------------------------------------------------------
  logic out_v_r;
  logic slot_free, send;
  logic s_outline, s_fe;
  col_t s_col;
  row_t s_row;
  logic [RES_N-1:0] sel;

  assign slot_free   = !out_v_r || out_ch.ready;
  assign send        = slot_free && (pend_r != '0);
  assign in_ch.ready = (pend_r == '0) || (slot_free && $onehot(pend_r));

  always_comb begin
    sel       = '0;
    s_outline = b_px_r;
    s_col     = b_col_r;
    s_row     = b_row_r;
    s_fe      = 1'b0;
    if (pend_r[RES_ABOVE]) begin
      sel[RES_ABOVE] = 1'b1;
      s_outline      = above_outline;
      s_row          = b_row_r - row_t'(1);
    end else if (pend_r[RES_LEFT]) begin
      sel[RES_LEFT] = 1'b1;
      s_outline     = b_left_r;
      s_col         = b_col_r - col_t'(1);
    end else if (pend_r[RES_OWN]) begin
      sel[RES_OWN] = 1'b1;
      s_fe         = 1'b1;
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (send) begin
      pend_nxt = pend_r & ~sel;
    end
    if (in_acc) begin
      pend_nxt = pend_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (slot_free) begin
        out_v_r <= send;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      out_ch.outline   <= s_outline;
      out_ch.col       <= s_col;
      out_ch.row       <= s_row;
      out_ch.frame_end <= s_fe;
    end
  end

  assign out_ch.valid = out_v_r;

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  logic in_room, acc_above, acc_first;

  assign in_room   = ($countones(pend_r) <= 1) && ((pend_r == '0) || slot_free);
  assign acc_above = in_acc && (row_r != '0);
  assign acc_first = in_acc && (row_r == '0) && !last_row;

  `BOPE_ASSERT_SAME(a_no_overrun, in_acc, in_room, "pixel taken while results queued")
  `BOPE_ASSERT_NEXT(a_above_queued, acc_above, pend_r[RES_ABOVE], "above result missing")
  `BOPE_ASSERT_NEXT(a_first_row_quiet, acc_first, pend_r == '0, "first row queued a result")
  `BOPE_ASSERT_NEXT(a_fwd_row_end, in_acc && !last_col, !fwd_r, "forwarding inside a row")

endmodule

### test/tb_binary_outline_pixel_extractor.sv
// Self-checking testbench for the binary outline pixel extractor.
`timescale 1ns / 100ps

module tb_binary_outline_pixel_extractor;
  import bope_pkg::*;

  // Idle cycles waited after the last expected result before a register is touched.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Length of the deliberate receiver hold-off in the back-pressure test.
  localparam int unsigned HOLD_CYCLES = 300;
  // Pixels to send in the randomised part of the run.
  localparam int unsigned RANDOM_ITEMS = 150;
  // Hard stop: several times the slowest correct run.
  localparam int unsigned TIMEOUT_NS = 2_000_000;

  typedef struct packed {
    logic outline;
    col_t col;
    row_t row;
    logic frame_end;
  } outline_result_t;

  logic clk = 1'b0;
  logic rst_n;

  bope_in_if  in_if ();
  bope_out_if out_if ();

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  binary_outline_pixel_extractor u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if.sink),
    .out_ch      (out_if.source),
    .cfg_psel    (psel),
    .cfg_penable (penable),
    .cfg_pwrite  (pwrite),
    .cfg_paddr   (paddr),
    .cfg_pwdata  (pwdata),
    .cfg_prdata  (prdata),
    .cfg_pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the testbench's own copy of the line stores, the raster position and
  // the size registers. The expected results wait in pending_outlines, oldest first.
  logic            newer_row [MAX_WIDTH];
  logic            older_row [MAX_WIDTH];
  int unsigned     col_pos;
  int unsigned     row_pos;
  logic            left_px;
  width_t          cfg_width;
  height_t         cfg_height;
  outline_result_t pending_outlines [$];

  int unsigned error_count;
  int unsigned random_items;
  // When set, neither the pixel sender nor the result receiver inserts any idle cycles.
  bit          no_idle;
  // Asks the receiver process to hold off for HOLD_CYCLES.
  bit          hold_request;

  // A size register of zero behaves as one, and anything above the maximum as the maximum.
  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned limit);
    return (v == 0) ? 1 : ((v > limit) ? limit : v);
  endfunction

  // Most pauses are short or absent; a few are long enough to drain or fill the block.
  function automatic int unsigned random_pause();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // A pixel is on the outline when it is set and any of its four neighbours is clear.
  function automatic void expect_outline(input logic centre, input logic west, input logic east,
                                         input logic north, input logic south,
                                         input int unsigned col, input int unsigned row,
                                         input logic frame_last);
    outline_result_t res;
    res.outline   = centre & ~(west & east & north & south);
    res.col       = col_t'(col);
    res.row       = row_t'(row);
    res.frame_end = frame_last;
    pending_outlines.push_back(res);
  endfunction

  // Works out the results that one accepted pixel transaction releases, in the order in
  // which the block delivers them: the pixel above, then the left neighbour on the last row,
  // then the pixel itself when it closes the frame.
  function automatic void predict_pixel(input logic px);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    logic        last_col;
    logic        last_row;
    w        = clamp_size(cfg_width, MAX_WIDTH);
    h        = clamp_size(cfg_height, MAX_HEIGHT);
    c        = col_pos;
    r        = row_pos;
    last_col = (c + 1 >= w);
    last_row = (r + 1 >= h);
    if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;

    // The pixel above now has its lower neighbour, so its result is complete.
    if (r >= 1) begin
      expect_outline(newer_row[c],
                     (c > 0) ? older_row[c-1] : 1'b0,
                     last_col ? 1'b0 : newer_row[c+1],
                     (r >= 2) ? older_row[c] : 1'b0,
                     px, c, r - 1, 1'b0);
    end

    older_row[c] = newer_row[c];
    newer_row[c] = px;

    // On the last row there is no row below, so the left neighbour is complete now,
    // and the closing pixel of the frame reports itself as well.
    if (last_row) begin
      if (c > 0) begin
        expect_outline(left_px,
                       (c >= 2) ? newer_row[c-2] : 1'b0,
                       px,
                       (r >= 1) ? older_row[c-1] : 1'b0,
                       1'b0, c - 1, r, 1'b0);
      end
      if (last_col) begin
        expect_outline(px,
                       (c > 0) ? left_px : 1'b0,
                       1'b0,
                       (r >= 1) ? older_row[c] : 1'b0,
                       1'b0, c, r, 1'b1);
      end
    end

    if (last_col) begin
      col_pos = 0;
      left_px = 1'b0;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      left_px = px;
    end
  endfunction

  // Offers one pixel, waits for its transaction, predicts its results and then idles for a
  // random gap. The valid is left high when no gap follows, so that the next pixel follows
  // without a bubble.
  task automatic send_pixel(input logic px);
    int unsigned gap;
    in_if.valid <= 1'b1;
    in_if.pixel <= px;
    do @(posedge clk); while (!in_if.ready);
    predict_pixel(px);
    gap = no_idle ? 0 : random_pause();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering pixels, waits for every expected result and lets the pipeline settle,
  // so that the size registers may then be written safely.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_outlines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reads one register over the configuration port and compares it with the expected value.
  task automatic check_reg(input logic reg_idx, input logic [CFG_DW-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register %0d read expected %0d, got %0d", $time, reg_idx, want, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes a size register, updates the predictor's copy and reads the register back.
  // Bits above the register's width are dropped by the block.
  task automatic write_size_reg(input logic reg_idx, input logic [CFG_DW-1:0] value);
    logic [CFG_DW-1:0] kept;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_IDX_WIDTH) begin
      cfg_width = value[WIDTH_W-1:0];
      kept      = CFG_DW'(cfg_width);
    end else begin
      cfg_height = value[HEIGHT_W-1:0];
      kept       = CFG_DW'(cfg_height);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    check_reg(reg_idx, kept);
  endtask

  task automatic set_frame_size(input logic [CFG_DW-1:0] w_reg, input logic [CFG_DW-1:0] h_reg);
    wait_idle();
    write_size_reg(REG_IDX_WIDTH, w_reg);
    write_size_reg(REG_IDX_HEIGHT, h_reg);
  endtask

  // Sends one whole frame holding a mostly solid rectangle on a sparse background, so that
  // outlines, holes and isolated specks all appear. noise_pct sets the background density.
  task automatic send_blob_frame(input logic [CFG_DW-1:0] w_reg, input logic [CFG_DW-1:0] h_reg,
                                 input int unsigned noise_pct, output int unsigned sent);
    int unsigned ew;
    int unsigned eh;
    int unsigned r0;
    int unsigned r1;
    int unsigned c0;
    int unsigned c1;
    logic        inside_blob;
    set_frame_size(w_reg, h_reg);
    ew = clamp_size(w_reg[WIDTH_W-1:0], MAX_WIDTH);
    eh = clamp_size(h_reg[HEIGHT_W-1:0], MAX_HEIGHT);
    r0 = $urandom_range(0, eh - 1);
    r1 = $urandom_range(r0, eh - 1);
    c0 = $urandom_range(0, ew - 1);
    c1 = $urandom_range(c0, ew - 1);
    for (int unsigned r = 0; r < eh; r++) begin
      for (int unsigned c = 0; c < ew; c++) begin
        inside_blob = (r >= r0) && (r <= r1) && (c >= c0) && (c <= c1);
        send_pixel(inside_blob ? ($urandom_range(0, 99) < 92)
                               : ($urandom_range(0, 99) < noise_pct));
      end
    end
    sent = ew * eh;
  endtask

  // The size registers must come out of reset at their documented defaults.
  task automatic test_register_reset();
    check_reg(REG_IDX_WIDTH, CFG_DW'(WIDTH_RST));
    check_reg(REG_IDX_HEIGHT, CFG_DW'(HEIGHT_RST));
  endtask

  // Zero sizes behave as a one-pixel image: every pixel is its own frame and reports only itself.
  task automatic test_single_pixel_frames();
    set_frame_size(0, 0);
    send_pixel(1'b1);
    send_pixel(1'b0);
  endtask

  // A solid square: only the centre pixel has four set neighbours.
  task automatic test_solid_square();
    set_frame_size(3, 3);
    repeat (9) send_pixel(1'b1);
  endtask

  // A one-pixel-wide image: left and right neighbours always lie outside the image.
  task automatic test_single_column();
    set_frame_size(1, 4);
    send_pixel(1'b1);
    send_pixel(1'b1);
    send_pixel(1'b1);
    send_pixel(1'b0);
  endtask

  // Sizes changed in the middle of the first row: the counters keep running, a column past
  // the new width ends its row, and a height cut to one makes the current row the last row.
  task automatic test_mid_frame_resize();
    set_frame_size(6, 3);
    send_pixel(1'b1);
    send_pixel(1'b1);
    send_pixel(1'b0);
    wait_idle();
    write_size_reg(REG_IDX_WIDTH, 2);
    send_pixel(1'b1);
    send_pixel(1'b1);
    send_pixel(1'b1);
    send_pixel(1'b1);
    send_pixel(1'b0);

    set_frame_size(4, 5);
    send_pixel(1'b1);
    send_pixel(1'b1);
    wait_idle();
    write_size_reg(REG_IDX_HEIGHT, 1);
    send_pixel(1'b1);
    send_pixel(1'b0);
  endtask

  // The receiver stops for a long stretch while pixels keep coming, so the block has to
  // fill up and refuse further pixel transactions until results drain again. The hold-off
  // has begun before the first pixel is offered.
  task automatic test_back_pressure();
    no_idle = 1'b1;
    set_frame_size(8, 4);
    hold_request = 1'b1;
    wait (!hold_request);
    repeat (32) send_pixel($urandom_range(0, 99) < 60);
    no_idle = 1'b0;
  endtask

  // Small random frames with random sizes; the unused upper register bits carry junk.
  task automatic test_random_frames();
    int unsigned      sent;
    logic [CFG_DW-1:0] w_reg;
    logic [CFG_DW-1:0] h_reg;
    while (random_items < RANDOM_ITEMS) begin
      w_reg = ($urandom_range(0, 99) < 10) ? 0 : $urandom_range(1, 16);
      h_reg = ($urandom_range(0, 99) < 10) ? 0 : $urandom_range(1, 10);
      w_reg = w_reg | (CFG_DW'($urandom_range(0, 255)) << 24);
      h_reg = h_reg | (CFG_DW'($urandom_range(0, 255)) << 24);
      send_blob_frame(w_reg, h_reg, ($urandom_range(0, 99) < 75) ? 5 : 50, sent);
      random_items += sent;
    end
  endtask

  // Register values just above the maximum must be clamped to it, not cut to the counter
  // width: a row runs past the truncated size before the size is cut back to end the frame.
  task automatic test_dimension_extremes();
    set_frame_size(MAX_WIDTH + 3, 2);
    repeat (8) send_pixel($urandom_range(0, 99) < 50);
    wait_idle();
    write_size_reg(REG_IDX_WIDTH, 4);
    repeat (5) send_pixel($urandom_range(0, 99) < 50);

    set_frame_size(2, MAX_HEIGHT + 3);
    repeat (10) send_pixel($urandom_range(0, 99) < 50);
    wait_idle();
    write_size_reg(REG_IDX_HEIGHT, 1);
    repeat (2) send_pixel($urandom_range(0, 99) < 50);
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.pixel  <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    cfg_width    = WIDTH_RST;
    cfg_height   = HEIGHT_RST;
    col_pos      = 0;
    row_pos      = 0;
    left_px      = 1'b0;
    error_count  = 0;
    random_items = 0;
    no_idle      = 1'b0;
    hold_request = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_reset();
    test_single_pixel_frames();
    test_solid_square();
    test_single_column();
    test_mid_frame_resize();
    test_back_pressure();
    test_random_frames();
    test_dimension_extremes();
    wait_idle();

    if (error_count == 0) begin
      $display("tb_binary_outline_pixel_extractor: PASS");
    end else begin
      $display("tb_binary_outline_pixel_extractor: FAIL");
    end
    $finish;
  end

  // Result receiver: ready toggles in random stretches, except when idling is switched off
  // or a long hold-off has been requested.
  initial begin : result_receiver
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat (no_idle ? 1 : $urandom_range(1, 6)) @(posedge clk);
        stall = no_idle ? 0 : random_pause();
        if (stall != 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Every result transaction is matched against the oldest expected result, field by field.
  always @(posedge clk) begin : check_results
    outline_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_outlines.size() == 0) begin
        $display("%0t: result with nothing expected: outline %0b col %0d row %0d frame_end %0b",
                 $time, out_if.outline, out_if.col, out_if.row, out_if.frame_end);
        error_count++;
      end else begin
        want = pending_outlines.pop_front();
        if (want.outline !== out_if.outline) begin
          $display("%0t: outline at (%0d,%0d) expected %0b, got %0b",
                   $time, want.col, want.row, want.outline, out_if.outline);
          error_count++;
        end
        if (want.col !== out_if.col) begin
          $display("%0t: col expected %0d, got %0d", $time, want.col, out_if.col);
          error_count++;
        end
        if (want.row !== out_if.row) begin
          $display("%0t: row expected %0d, got %0d", $time, want.row, out_if.row);
          error_count++;
        end
        if (want.frame_end !== out_if.frame_end) begin
          $display("%0t: frame_end at (%0d,%0d) expected %0b, got %0b",
                   $time, want.col, want.row, want.frame_end, out_if.frame_end);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("%0t: timed out with %0d results outstanding", $time, pending_outlines.size());
    $display("tb_binary_outline_pixel_extractor: FAIL");
    $finish;
  end

endmodule
